### rtl/dzos_pkg.sv
// ----------------------------------------------------------------------------
// dzos_pkg
// Shared types, constants and helpers for the depth-zone steering unit.
// ----------------------------------------------------------------------------
package dzos_pkg;

	localparam int IMG_WIDTH    = 640;
	localparam int ZONE_WIDTH   = 128;
	localparam int CENTER_START = 256;
	localparam int RIGHT_START  = 512;

	localparam int DEPTH_W = 16;
	localparam int CNT_W   = 16;
	localparam int REG_W   = 16;
	localparam int IDX_W   = 2;
	localparam int COL_W   = $clog2(IMG_WIDTH);
	localparam int CMP_W   = 12;

	localparam logic [IDX_W-1:0] REG_NEAR_LIMIT    = 2'd0;
	localparam logic [IDX_W-1:0] REG_FAR_LIMIT     = 2'd1;
	localparam logic [IDX_W-1:0] REG_MIN_AREA      = 2'd2;
	localparam logic [IDX_W-1:0] REG_WINDOW_FRAMES = 2'd3;

	localparam logic [REG_W-1:0] NEAR_RST   = 16'd300;
	localparam logic [REG_W-1:0] FAR_RST    = 16'd800;
	localparam logic [REG_W-1:0] AREA_RST   = 16'd1000;
	localparam logic [REG_W-1:0] WINDOW_RST = 16'd1;

	typedef enum logic [2:0] {
		SIT_CLEAR     = 3'd0,
		SIT_RIGHT_ONE = 3'd1,
		SIT_RIGHT_TWO = 3'd2,
		SIT_LEFT_ONE  = 3'd3,
		SIT_LEFT_TWO  = 3'd4,
		SIT_MIDDLE    = 3'd5,
		SIT_SIDES     = 3'd6,
		SIT_ALL       = 3'd7
	} sit_t;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_FWD   = 2'd1,
		ST_LEFT  = 2'd2,
		ST_RIGHT = 2'd3
	} steer_t;

	// per-pixel flags carried by the input stage
	typedef struct packed {
		logic inc_left;
		logic inc_center;
		logic inc_right;
		logic frame_end;
		logic coin;
	} pix_flags_t;

	typedef struct packed {
		logic left;
		logic center;
		logic right;
	} zone_hits_t;

	typedef struct packed {
		logic   left_hit;
		logic   center_hit;
		logic   right_hit;
		sit_t   situation;
		steer_t steer;
	} result_t;

	function automatic logic in_zone(input logic [COL_W-1:0] col, input int start);
		logic [CMP_W-1:0] c;
		c = CMP_W'(col);
		return (c >= CMP_W'(start)) && (c < CMP_W'(start + ZONE_WIDTH));
	endfunction

	function automatic sit_t sit_of_hits(input zone_hits_t h);
		sit_t s;
		unique case ({h.left, h.center, h.right})
			3'b000: s = SIT_CLEAR;
			3'b001: s = SIT_RIGHT_ONE;
			3'b010: s = SIT_MIDDLE;
			3'b011: s = SIT_RIGHT_TWO;
			3'b100: s = SIT_LEFT_ONE;
			3'b101: s = SIT_SIDES;
			3'b110: s = SIT_LEFT_TWO;
			3'b111: s = SIT_ALL;
			default: s = SIT_CLEAR;
		endcase
		return s;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

### rtl/dzos_pix_if.sv
// ----------------------------------------------------------------------------
// dzos_pix_if
// Depth pixel channel: valid/ready with depth, frame_end and coin.
// ----------------------------------------------------------------------------
interface dzos_pix_if import dzos_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] depth;
	logic               frame_end;
	logic               coin;

	modport source (output valid, depth, frame_end, coin, input ready);
	modport sink   (input valid, depth, frame_end, coin, output ready);
endinterface

interface dzos_res_if ();
	logic       valid;
	logic       ready;
	logic       left_hit;
	logic       center_hit;
	logic       right_hit;
	logic [2:0] situation;
	logic [1:0] steer;

	modport source (output valid, left_hit, center_hit, right_hit, situation, steer,
		input ready);
	modport sink   (input valid, left_hit, center_hit, right_hit, situation, steer,
		output ready);
endinterface

### rtl/depth_zone_obstacle_steering_unit.sv
// ----------------------------------------------------------------------------
// depth_zone_obstacle_steering_unit
// Counts in-range depth pixels in three column zones and steers at frame end.
// ----------------------------------------------------------------------------
// The unit takes one depth pixel per clock cycle while input ready is high.
// Each accepted pixel is classified and tagged with its zones in the input
// register, and the next cycle adds it to the zone counters; a frame-end
// pixel instead, as it leaves that register, has the counts compared, the
// situation and command picked and the result register loaded, so a result
// passes the input and result registers. Ordinary pixels never wait; a
// frame-end pixel waits in the input register only while the previous result
// is still held and not taken, and input ready drops meanwhile. There is no
// clearing pass after reset. Configuration writes are meant for idle periods.
// ----------------------------------------------------------------------------
module depth_zone_obstacle_steering_unit import dzos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	dzos_pix_if.sink         pix,
	dzos_res_if.source       res,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data
);

	logic [REG_W-1:0] near_q, far_q, area_q, window_q;
	logic             valid_s1;
	pix_flags_t       flags_s1;
	zone_hits_t       hits;
	logic             out_valid;
	result_t          result;
	logic             advance;
	logic             frame_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q   <= NEAR_RST;
			far_q    <= FAR_RST;
			area_q   <= AREA_RST;
			window_q <= WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEAR_LIMIT:    near_q   <= cfg_data;
				REG_FAR_LIMIT:     far_q    <= cfg_data;
				REG_MIN_AREA:      area_q   <= cfg_data;
				REG_WINDOW_FRAMES: window_q <= cfg_data;
			endcase
		end
	end

	// hold a frame-end beat while the result register is occupied and not taken
	assign advance    = valid_s1 && (!flags_s1.frame_end || !out_valid || res.ready);
	assign frame_step = advance && flags_s1.frame_end;

	dzos_pixel_stage u_pixel (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pix.valid),
		.in_ready   (pix.ready),
		.depth      (pix.depth),
		.frame_end  (pix.frame_end),
		.coin       (pix.coin),
		.near_limit (near_q),
		.far_limit  (far_q),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.flags_s1   (flags_s1)
	);

	dzos_zone_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.flags_s1 (flags_s1),
		.min_area (area_q),
		.hits     (hits)
	);

	dzos_steer u_steer (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_step    (frame_step),
		.hits          (hits),
		.coin          (flags_s1.coin),
		.window_frames (window_q),
		.out_ready     (res.ready),
		.out_valid     (out_valid),
		.result        (result)
	);

	assign res.valid      = out_valid;
	assign res.left_hit   = result.left_hit;
	assign res.center_hit = result.center_hit;
	assign res.right_hit  = result.right_hit;
	assign res.situation  = result.situation;
	assign res.steer      = result.steer;

endmodule

### rtl/dzos_pixel_stage.sv
// ----------------------------------------------------------------------------
// dzos_pixel_stage
// Input register: tracks the column, classifies the pixel and flags its zones.
// ----------------------------------------------------------------------------
module dzos_pixel_stage import dzos_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [DEPTH_W-1:0] depth,
	input  logic               frame_end,
	input  logic               coin,
	input  logic [REG_W-1:0]   near_limit,
	input  logic [REG_W-1:0]   far_limit,
	input  logic               advance,
	output logic               valid_s1,
	output pix_flags_t         flags_s1
);

	logic [COL_W-1:0] col_q;
	logic             accept;
	logic             obstacle;
	logic             s1_valid_q;
	pix_flags_t       s1_flags_q;

	assign in_ready = !s1_valid_q || advance;
	assign accept   = in_valid && in_ready;
	assign obstacle = (depth >= near_limit) && (depth <= far_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				// row wraps silently; frame end restarts at column zero
				if (frame_end || col_q == COL_W'(IMG_WIDTH - 1))
					col_q <= '0;
				else
					col_q <= col_q + COL_W'(1);
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_flags_q.inc_left   <= obstacle && in_zone(col_q, 0);
			s1_flags_q.inc_center <= obstacle && in_zone(col_q, CENTER_START);
			s1_flags_q.inc_right  <= obstacle && in_zone(col_q, RIGHT_START);
			s1_flags_q.frame_end  <= frame_end;
			s1_flags_q.coin       <= coin;
		end
	end

	assign valid_s1 = s1_valid_q;
	assign flags_s1 = s1_flags_q;

endmodule

### rtl/dzos_zone_accum.sv
// ----------------------------------------------------------------------------
// dzos_zone_accum
// Saturating obstacle counters for the three zones and the hit compare.
// ----------------------------------------------------------------------------
module dzos_zone_accum import dzos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  pix_flags_t       flags_s1,
	input  logic [REG_W-1:0] min_area,
	output zone_hits_t       hits
);

	logic [CNT_W-1:0] left_q, center_q, right_q;
	logic [CNT_W-1:0] left_nx, center_nx, right_nx;

	// include the current pixel before the frame-end compare
	assign left_nx   = flags_s1.inc_left   ? sat_inc(left_q)   : left_q;
	assign center_nx = flags_s1.inc_center ? sat_inc(center_q) : center_q;
	assign right_nx  = flags_s1.inc_right  ? sat_inc(right_q)  : right_q;

	assign hits.left   = left_nx   > min_area;
	assign hits.center = center_nx > min_area;
	assign hits.right  = right_nx  > min_area;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			center_q <= '0;
			right_q  <= '0;
		end else if (advance) begin
			if (flags_s1.frame_end) begin
				left_q   <= '0;
				center_q <= '0;
				right_q  <= '0;
			end else begin
				left_q   <= left_nx;
				center_q <= center_nx;
				right_q  <= right_nx;
			end
		end
	end

endmodule

### rtl/dzos_steer.sv
// ----------------------------------------------------------------------------
// dzos_steer
// Frame-end decision: situation, steering choice, history and result register.
// ----------------------------------------------------------------------------
module dzos_steer import dzos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_step,
	input  zone_hits_t       hits,
	input  logic             coin,
	input  logic [REG_W-1:0] window_frames,
	input  logic             out_ready,
	output logic             out_valid,
	output result_t          result
);

	sit_t             last_sit_q;
	steer_t           last_steer_q;
	logic [CNT_W-1:0] since_q;
	logic             out_valid_q;
	result_t          result_q;

	sit_t             sit;
	steer_t           steer;
	steer_t           coin_turn;
	logic [CNT_W-1:0] elapsed;
	logic             recent;
	logic             prev_left;
	logic             prev_right;
	logic             last_turned;

	assign sit         = sit_of_hits(hits);
	assign elapsed     = sat_inc(since_q);
	assign recent      = elapsed <= window_frames;
	assign prev_left   = (last_sit_q == SIT_LEFT_ONE || last_sit_q == SIT_LEFT_TWO) && recent;
	assign prev_right  = (last_sit_q == SIT_RIGHT_ONE || last_sit_q == SIT_RIGHT_TWO) && recent;
	assign last_turned = (last_steer_q == ST_LEFT) || (last_steer_q == ST_RIGHT);
	assign coin_turn   = coin ? ST_RIGHT : ST_LEFT;

	always_comb begin
		unique case (sit)
			SIT_CLEAR:                   steer = ST_FWD;
			SIT_RIGHT_ONE, SIT_RIGHT_TWO: steer = prev_left ? ST_RIGHT : ST_LEFT;
			SIT_LEFT_ONE, SIT_LEFT_TWO:   steer = prev_right ? ST_LEFT : ST_RIGHT;
			SIT_SIDES:                   steer = last_turned ? last_steer_q : coin_turn;
			SIT_MIDDLE, SIT_ALL: begin
				// after no command at all, stay silent
				if (last_turned)
					steer = last_steer_q;
				else if (last_steer_q == ST_NONE)
					steer = ST_NONE;
				else
					steer = coin_turn;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sit_q   <= SIT_CLEAR;
			last_steer_q <= ST_NONE;
			since_q      <= '1;
			out_valid_q  <= 1'b0;
		end else begin
			if (frame_step) begin
				out_valid_q <= 1'b1;
				if (sit != SIT_CLEAR) begin
					last_sit_q <= sit;
					since_q    <= '0;
				end else begin
					since_q    <= elapsed;
				end
				if (steer != ST_NONE)
					last_steer_q <= steer;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_step) begin
			result_q.left_hit   <= hits.left;
			result_q.center_hit <= hits.center;
			result_q.right_hit  <= hits.right;
			result_q.situation  <= sit;
			result_q.steer      <= steer;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

### rtl/dzos_checker.sv
// ----------------------------------------------------------------------------
// dzos_checker
// Port-level checks for the steering unit, bound to the top level.
// ----------------------------------------------------------------------------
module dzos_checker import dzos_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       left_hit,
	input logic       center_hit,
	input logic       right_hit,
	input logic [2:0] situation,
	input logic [1:0] steer
);

	logic [1:0] last_cmd_q;
	logic       last_turn;
	logic       repeats;

	// last command other than none among delivered beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_cmd_q <= ST_NONE;
		else if (out_valid && out_ready && steer != ST_NONE)
			last_cmd_q <= steer;
	end

	assign last_turn = (last_cmd_q == ST_LEFT) || (last_cmd_q == ST_RIGHT);
	assign repeats   = (situation == SIT_MIDDLE) || (situation == SIT_ALL)
		|| (situation == SIT_SIDES);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
		&& $stable({left_hit, center_hit, right_hit, situation, steer}))
		else $error("result beat changed while stalled");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	a_turn_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_turn && repeats |-> steer == last_cmd_q)
		else $error("blocked frame did not repeat the last turn");

endmodule

bind depth_zone_obstacle_steering_unit dzos_checker u_dzos_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (pix.ready),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.left_hit   (res.left_hit),
	.center_hit (res.center_hit),
	.right_hit  (res.right_hit),
	.situation  (res.situation),
	.steer      (res.steer)
);
